// ----- src/sal_pkg.sv -----
// shared codes and types for the shifting array list
package sal_pkg;

	// operation codes of an input beat
	localparam logic [1:0] KIND_INS  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_FIND = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_MISS  = 2'd3;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic find;
	} sal_ctl_t;

endpackage

// ----- src/shifting_array_list.sv -----
// shifting array list top level: a row of cells with an ordered list and a count
// insert and erase: result registered in the cycle after the beat is taken
// find: compare and isolate registered, then encoded result once output is free
// one item in flight: insert and erase take a beat every cycle while output is free
// reset empties the list and clears the output valid; cell contents stay undefined
module shifting_array_list #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [$clog2(CAPACITY+1)-1:0]  position,
	input  logic signed [31:0]             value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [$clog2(CAPACITY)-1:0]    found_index,
	output logic [$clog2(CAPACITY+1)-1:0]  count
);
	import sal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PICK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nxt;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] count_q;

	logic          in_acc;
	logic          out_free;
	logic          ins_range;
	logic          full;
	logic          del_ok;
	logic [1:0]    status_imm;
	sal_ctl_t      ctl;

	logic [31:0]   ent [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [IW-1:0] pick_idx;
	logic          pick_hit;

	// handshakes
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	// range and capacity checks against the current count
	assign ins_range = (position > cnt_q);
	assign full      = (cnt_q == CW'(CAPACITY));
	assign del_ok    = (position < cnt_q);

	assign ctl.ins  = in_acc && (kind == KIND_INS) && !ins_range && !full;
	assign ctl.del  = in_acc && (kind == KIND_DEL) && del_ok;
	assign ctl.find = in_acc && (kind == KIND_FIND);

	// immediate status for insert and erase
	always_comb begin
		unique case (kind)
			KIND_INS: begin
				if (ins_range) begin
					status_imm = STAT_RANGE;
				end else if (full) begin
					status_imm = STAT_FULL;
				end else begin
					status_imm = STAT_OK;
				end
			end
			KIND_DEL: status_imm = del_ok ? STAT_OK : STAT_RANGE;
			default:  status_imm = STAT_RANGE;
		endcase
	end

	// count after this beat
	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.ins) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (ctl.del) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	// row of cells, each fed by its lower and upper neighbor (value and zero at the ends)
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [31:0] lower_w;
		logic [31:0] upper_w;
		if (g == 0) begin : g_lo_edge
			assign lower_w = value;
		end else begin : g_lo
			assign lower_w = ent[g-1];
		end
		if (g == CAPACITY - 1) begin : g_hi_edge
			assign upper_w = '0;
		end else begin : g_hi
			assign upper_w = ent[g+1];
		end
		sal_cell #(
			.IDX (g),
			.PW  (CW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (position),
			.cnt   (cnt_q),
			.din   (value),
			.lower (lower_w),
			.upper (upper_w),
			.entry (ent[g]),
			.match (match[g])
		);
	end

	// first matching cell
	sal_pick #(
		.N  (CAPACITY),
		.IW (IW)
	) u_pick (
		.clk   (clk),
		.en    (state_q == S_PICK),
		.match (match),
		.idx   (pick_idx),
		.hit   (pick_hit)
	);

	// control: sequencer, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (ctl.find) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((in_acc && (kind != KIND_FIND)) || ((state_q == S_DONE) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (in_acc && (kind != KIND_FIND)) begin
			status_q <= status_imm;
			idx_q    <= '0;
			count_q  <= cnt_nxt;
		end else if ((state_q == S_DONE) && out_free) begin
			status_q <= pick_hit ? STAT_OK : STAT_MISS;
			idx_q    <= pick_idx;
			count_q  <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = idx_q;
	assign count       = count_q;

endmodule

// ----- src/sal_cell.sv -----
// one list cell: holds an entry, shifts with its neighbors, flags a match
module sal_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic             clk,
	input  sal_pkg::sal_ctl_t ctl,
	input  logic [PW-1:0]    pos,
	input  logic [PW-1:0]    cnt,
	input  logic [31:0]      din,
	input  logic [31:0]      lower,
	input  logic [31:0]      upper,
	output logic [31:0]      entry,
	output logic             match
);
	import sal_pkg::*;

	logic [31:0] entry_q;
	logic        match_q;
	logic        at_pos;
	logic        above_pos;
	logic        in_list;

	// where this cell sits relative to the operation position and the count
	assign at_pos    = (pos == PW'(IDX));
	assign above_pos = (pos < PW'(IDX));
	assign in_list   = (PW'(IDX) < cnt);

	// shift up on insert, shift down on erase, compare on find
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				entry_q <= din;
			end else if (above_pos) begin
				entry_q <= lower;
			end
		end else if (ctl.del) begin
			if (at_pos || above_pos) begin
				entry_q <= upper;
			end
		end
		if (ctl.find) begin
			match_q <= (entry_q == din) && in_list;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ----- src/sal_pick.sv -----
// first-match selection: isolate the lowest set match bit, then encode it
module sal_pick #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          en,
	input  logic [N-1:0]  match,
	output logic [IW-1:0] idx,
	output logic          hit
);
	logic [N-1:0]  onehot_q;
	logic [IW-1:0] idx_c;

	// keep only the lowest set bit
	always_ff @(posedge clk) begin
		if (en) begin
			onehot_q <= match & (~match + N'(1));
		end
	end

	// one-hot to binary as an or per index bit
	always_comb begin
		idx_c = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot_q[i]) begin
				idx_c = idx_c | IW'(i);
			end
		end
	end

	assign idx = idx_c;
	assign hit = |onehot_q;

endmodule
